@@ rtl/wss_pkg.sv @@
// Shared constants and types for the window SNR statistics block.
package wss_pkg;

    localparam int MAX_PIXELS_DEF = 4096;

    localparam int PIX_W   = 32;
    localparam int TOL_W   = 31;
    localparam int COUNT_W = 13;
    localparam int STD_W   = 31;
    localparam int DB_W    = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NODATA_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODATA_VALUE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NODATA_TOLERANCE = 2'd2;

    // 20*log10(2) in Q16.16
    localparam logic signed [19:0] DB_FACTOR_Q16 = 20'sd394566;

    // Divider width
    localparam int DVD_W = 64;
    localparam int DVS_W = 32;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } wss_div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
    } wss_div_rsp_t;

endpackage

@@ rtl/wss_if.sv @@
// Handshake channel interfaces: pixel input, result output, configuration write.
interface wss_pix_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pixel_value;
    logic               not_finite;
    logic               last_of_window;

    modport source (output valid, pixel_value, not_finite, last_of_window, input ready);
    modport sink   (input valid, pixel_value, not_finite, last_of_window, output ready);
endinterface

interface wss_res_if;
    logic               valid;
    logic               ready;
    logic [12:0]        valid_count;
    logic signed [31:0] mean_value;
    logic [30:0]        std_deviation;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic signed [31:0] snr_linear;
    logic signed [15:0] snr_decibel;

    modport source (output valid, valid_count, mean_value, std_deviation, min_value,
                    max_value, snr_linear, snr_decibel, input ready);
    modport sink   (input valid, valid_count, mean_value, std_deviation, min_value,
                    max_value, snr_linear, snr_decibel, output ready);
endinterface

interface wss_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [31:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

@@ rtl/window_snr_statistics_top.sv @@
// Window statistics top level: pixel store, running extremes, mean, std deviation and SNR.
// Flow: one pixel word per cycle while loading; after the last word the result is computed
//   from the n kept pixels: up to three divides, a pass over the store through the deviation
//   pipeline, a 32-step square root, a normalise shift and a 16-step log2 (square, then step).
// Input: the compute phase blocks input until the result is handed over.
// Reset: registers at 0 / 0 / 1, window state cleared; the pixel store is not cleared.
module window_snr_statistics_top #(
    parameter int MAX_PIXELS = wss_pkg::MAX_PIXELS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    wss_pix_if.sink    pix,
    wss_res_if.source  res,
    wss_cfg_if.sink    cfg
);
    import wss_pkg::*;

    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int SUM_W  = PIX_W + CNT_W;

    typedef enum logic [11:0] {
        S_LOAD     = 12'b000000000001,
        S_MEAN     = 12'b000000000010,
        S_PASS     = 12'b000000000100,
        S_VAR      = 12'b000000001000,
        S_SQRT     = 12'b000000010000,
        S_SNR      = 12'b000000100000,
        S_NORM     = 12'b000001000000,
        S_LOG_SQ   = 12'b000010000000,
        S_LOG_STEP = 12'b000100000000,
        S_DB_MUL   = 12'b001000000000,
        S_DB       = 12'b010000000000,
        S_OUT      = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic                    nd_en_reg;
    logic signed [PIX_W-1:0] nd_val_reg;
    logic [TOL_W-1:0]        nd_tol_reg;

    // Window state
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [PIX_W-1:0] min_reg, min_next;
    logic signed [PIX_W-1:0] max_reg, max_next;

    // Compute state
    logic                    pend_reg, pend_next;
    logic signed [PIX_W:0]   mean_reg, mean_next;
    logic [CNT_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                    s1_v_reg, s2_v_reg, s3_v_reg;
    logic [PIX_W-1:0]        s2_abs_reg;
    logic [63:0]             s3_sq_reg;
    logic [63:0]             dsum_reg, dsum_next;
    logic [63:0]             sq_v_reg, sq_v_next;
    logic [63:0]             sq_r_reg, sq_r_next;
    logic [63:0]             sq_b_reg, sq_b_next;
    logic [4:0]              sq_i_reg, sq_i_next;
    logic [STD_W-1:0]        std_reg, std_next;
    logic signed [PIX_W-1:0] snr_reg, snr_next;
    logic [PIX_W-1:0]        nx_reg, nx_next;
    logic [4:0]              sh_reg, sh_next;
    logic [30:0]             m_reg, m_next;
    logic [61:0]             msq_reg, msq_next;
    logic [15:0]             frac_reg, frac_next;
    logic [3:0]              lg_i_reg, lg_i_next;
    logic signed [41:0]      dbp_reg, dbp_next;
    logic signed [DB_W-1:0]  db_reg, db_next;

    // Output register
    logic                    out_v_reg, out_v_next;
    logic [COUNT_W-1:0]      o_cnt_reg;
    logic signed [PIX_W-1:0] o_mean_reg, o_min_reg, o_max_reg, o_snr_reg;
    logic [STD_W-1:0]        o_std_reg;
    logic signed [DB_W-1:0]  o_db_reg;
    logic                    out_load;

    wss_div_req_t div_req;
    wss_div_rsp_t div_rsp;

    logic                    pix_acc;
    logic signed [PIX_W:0]   nd_diff;
    logic [PIX_W:0]          nd_abs;
    logic                    keep;
    logic                    ram_we;
    logic [PIX_W-1:0]        ram_rdata;
    logic [SUM_W-1:0]        sum_abs;
    logic signed [PIX_W+1:0] dev;
    logic [PIX_W+1:0]        dev_abs;
    logic [64:0]             acc;
    logic [63:0]             sq_try;
    logic [31:0]             lg_t;
    logic signed [21:0]      log_q16;
    logic signed [41:0]      db_round;
    logic signed [17:0]      db_wide;
    logic                    pass_issue;

    assign pix.ready = (state_reg == S_LOAD);
    assign cfg.ready = 1'b1;
    assign pix_acc   = pix.valid && pix.ready;

    // Decide whether the incoming word is kept
    always_comb
    begin
        nd_diff = {pix.pixel_value[PIX_W-1], pix.pixel_value}
                  - {nd_val_reg[PIX_W-1], nd_val_reg};
        nd_abs  = nd_diff[PIX_W] ? (PIX_W+1)'(-nd_diff) : (PIX_W+1)'(nd_diff);
        keep    = !pix.not_finite
                  && !(nd_en_reg && (nd_abs < {2'b00, nd_tol_reg}))
                  && (cnt_reg < CNT_W'(MAX_PIXELS));
    end

    assign ram_we = pix_acc && keep;

    wss_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (pix.pixel_value),
        .raddr (rd_idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    wss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_load = (state_reg == S_OUT) && (!out_v_reg || res.ready);

    // Main sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        sum_next    = sum_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        pend_next   = pend_reg;
        mean_next   = mean_reg;
        rd_idx_next = rd_idx_reg;
        dsum_next   = dsum_reg;
        sq_v_next   = sq_v_reg;
        sq_r_next   = sq_r_reg;
        sq_b_next   = sq_b_reg;
        sq_i_next   = sq_i_reg;
        std_next    = std_reg;
        snr_next    = snr_reg;
        nx_next     = nx_reg;
        sh_next     = sh_reg;
        m_next      = m_reg;
        msq_next    = msq_reg;
        frac_next   = frac_reg;
        lg_i_next   = lg_i_reg;
        dbp_next    = dbp_reg;
        db_next     = db_reg;
        div_req     = '0;
        pass_issue  = 1'b0;
        sum_abs     = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        acc         = {1'b0, dsum_reg} + {1'b0, s3_sq_reg};
        sq_try      = sq_r_reg + sq_b_reg;
        lg_t        = msq_reg[61:30];
        log_q16     = {6'(6'sd15 - $signed({1'b0, sh_reg})), frac_reg};
        db_round    = dbp_reg + 42'sd8388608;
        db_wide     = db_round[41:24];

        case (state_reg)
            S_LOAD:
            begin
                if (pix_acc)
                begin
                    if (keep)
                    begin
                        if (cnt_reg == '0 || pix.pixel_value < min_reg)
                        begin
                            min_next = pix.pixel_value;
                        end
                        if (cnt_reg == '0 || pix.pixel_value > max_reg)
                        begin
                            max_next = pix.pixel_value;
                        end
                        sum_next = sum_reg + SUM_W'(pix.pixel_value);
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (pix.last_of_window)
                    begin
                        state_next = S_MEAN;
                    end
                end
            end

            S_MEAN:
            begin
                if (cnt_reg == '0)
                begin
                    mean_next  = '0;
                    std_next   = '0;
                    snr_next   = '0;
                    db_next    = '0;
                    state_next = S_OUT;
                end
                else if (!pend_reg)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = 64'(sum_abs) + 64'(cnt_reg >> 1);
                    div_req.divisor  = 32'(cnt_reg);
                    pend_next        = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    pend_next   = 1'b0;
                    mean_next   = sum_reg[SUM_W-1] ? -$signed(div_rsp.quotient[PIX_W:0])
                                                   : $signed(div_rsp.quotient[PIX_W:0]);
                    rd_idx_next = '0;
                    dsum_next   = '0;
                    state_next  = S_PASS;
                end
            end

            S_PASS:
            begin
                // Issue reads, accumulate squared deviations as they drain
                if (rd_idx_reg < cnt_reg)
                begin
                    pass_issue  = 1'b1;
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (s3_v_reg)
                begin
                    dsum_next = acc[64] ? '1 : acc[63:0];
                end
                if (!pass_issue && !s1_v_reg && !s2_v_reg && !s3_v_reg)
                begin
                    if (cnt_reg > CNT_W'(1))
                    begin
                        state_next = S_VAR;
                    end
                    else
                    begin
                        std_next   = '0;
                        state_next = S_SNR;
                    end
                end
            end

            S_VAR:
            begin
                if (!pend_reg)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = dsum_reg;
                    div_req.divisor  = 32'(cnt_reg - 1'b1);
                    pend_next        = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    pend_next  = 1'b0;
                    sq_v_next  = div_rsp.quotient;
                    sq_r_next  = '0;
                    sq_b_next  = 64'h4000_0000_0000_0000;
                    sq_i_next  = '0;
                    state_next = S_SQRT;
                end
            end

            S_SQRT:
            begin
                // One root bit per cycle, from one bit pair of the radicand
                if (sq_v_reg >= sq_try)
                begin
                    sq_v_next = sq_v_reg - sq_try;
                    sq_r_next = (sq_r_reg >> 1) + sq_b_reg;
                end
                else
                begin
                    sq_r_next = sq_r_reg >> 1;
                end
                sq_b_next = sq_b_reg >> 2;
                sq_i_next = sq_i_reg + 1'b1;
                if (sq_i_reg == 5'd31)
                begin
                    std_next   = (sq_r_next > 64'h7FFF_FFFF) ? '1 : sq_r_next[STD_W-1:0];
                    state_next = S_SNR;
                end
            end

            S_SNR:
            begin
                if (std_reg == '0)
                begin
                    snr_next   = '0;
                    db_next    = '0;
                    state_next = S_OUT;
                end
                else if (!pend_reg)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {16'd0,
                                        (mean_reg[PIX_W] ? PIX_W'(-mean_reg) : PIX_W'(mean_reg)),
                                        16'd0};
                    div_req.divisor  = 32'(std_reg);
                    pend_next        = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    pend_next = 1'b0;
                    if (mean_reg[PIX_W])
                    begin
                        snr_next = (div_rsp.quotient > 64'h8000_0000) ? 32'sh8000_0000
                                 : -$signed(div_rsp.quotient[PIX_W-1:0]);
                        db_next    = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        snr_next = (div_rsp.quotient > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                 : $signed(div_rsp.quotient[PIX_W-1:0]);
                        if (div_rsp.quotient == '0)
                        begin
                            db_next    = '0;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            nx_next    = (div_rsp.quotient > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                       : div_rsp.quotient[PIX_W-1:0];
                            sh_next    = '0;
                            state_next = S_NORM;
                        end
                    end
                end
            end

            S_NORM:
            begin
                // Shift left until the leading one reaches the top
                if (nx_reg[PIX_W-1])
                begin
                    m_next     = nx_reg[PIX_W-1:1];
                    frac_next  = '0;
                    lg_i_next  = '0;
                    state_next = S_LOG_SQ;
                end
                else
                begin
                    nx_next = nx_reg << 1;
                    sh_next = sh_reg + 1'b1;
                end
            end

            S_LOG_SQ:
            begin
                msq_next   = 62'(m_reg) * 62'(m_reg);
                state_next = S_LOG_STEP;
            end

            S_LOG_STEP:
            begin
                if (lg_t[31])
                begin
                    frac_next = {frac_reg[14:0], 1'b1};
                    m_next    = lg_t[31:1];
                end
                else
                begin
                    frac_next = {frac_reg[14:0], 1'b0};
                    m_next    = lg_t[30:0];
                end
                lg_i_next = lg_i_reg + 1'b1;
                if (lg_i_reg == 4'd15)
                begin
                    state_next = S_DB_MUL;
                end
                else
                begin
                    state_next = S_LOG_SQ;
                end
            end

            S_DB_MUL:
            begin
                dbp_next   = 42'(log_q16) * 42'(DB_FACTOR_Q16);
                state_next = S_DB;
            end

            S_DB:
            begin
                if (db_wide > 18'sd32767)
                begin
                    db_next = 16'sh7FFF;
                end
                else if (db_wide < -18'sd32768)
                begin
                    db_next = 16'sh8000;
                end
                else
                begin
                    db_next = db_wide[DB_W-1:0];
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                // Hand the result over and clear the window
                if (out_load)
                begin
                    cnt_next   = '0;
                    sum_next   = '0;
                    min_next   = '0;
                    max_next   = '0;
                    state_next = S_LOAD;
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Deviation pipeline: read data, absolute deviation, square
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= pass_issue;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_comb
    begin
        dev     = $signed({{2{ram_rdata[PIX_W-1]}}, ram_rdata})
                  - $signed({mean_reg[PIX_W], mean_reg});
        dev_abs = dev[PIX_W+1] ? (PIX_W+2)'(-dev) : (PIX_W+2)'(dev);
    end

    always_ff @(posedge clk)
    begin
        s2_abs_reg <= dev_abs[PIX_W-1:0];
        s3_sq_reg  <= 64'(s2_abs_reg) * 64'(s2_abs_reg);
    end

    // Output register
    always_comb
    begin
        out_v_next = out_v_reg;
        if (res.ready)
        begin
            out_v_next = 1'b0;
        end
        if (out_load)
        begin
            out_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_cnt_reg  <= COUNT_W'(cnt_reg);
            o_mean_reg <= mean_reg[PIX_W-1:0];
            o_std_reg  <= std_reg;
            o_min_reg  <= min_reg;
            o_max_reg  <= max_reg;
            o_snr_reg  <= snr_reg;
            o_db_reg   <= db_reg;
        end
    end

    assign res.valid         = out_v_reg;
    assign res.valid_count   = o_cnt_reg;
    assign res.mean_value    = o_mean_reg;
    assign res.std_deviation = o_std_reg;
    assign res.min_value     = o_min_reg;
    assign res.max_value     = o_max_reg;
    assign res.snr_linear    = o_snr_reg;
    assign res.snr_decibel   = o_db_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            cnt_reg    <= '0;
            sum_reg    <= '0;
            min_reg    <= '0;
            max_reg    <= '0;
            pend_reg   <= 1'b0;
            out_v_reg  <= 1'b0;
            nd_en_reg  <= 1'b0;
            nd_val_reg <= '0;
            nd_tol_reg <= TOL_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            pend_reg  <= pend_next;
            out_v_reg <= out_v_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.reg_index)
                    CFG_NODATA_ENABLE:    nd_en_reg  <= cfg.wdata[0];
                    CFG_NODATA_VALUE:     nd_val_reg <= cfg.wdata;
                    CFG_NODATA_TOLERANCE: nd_tol_reg <= cfg.wdata[TOL_W-1:0];
                    default:              nd_en_reg  <= nd_en_reg;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        mean_reg   <= mean_next;
        rd_idx_reg <= rd_idx_next;
        dsum_reg   <= dsum_next;
        sq_v_reg   <= sq_v_next;
        sq_r_reg   <= sq_r_next;
        sq_b_reg   <= sq_b_next;
        sq_i_reg   <= sq_i_next;
        std_reg    <= std_next;
        snr_reg    <= snr_next;
        nx_reg     <= nx_next;
        sh_reg     <= sh_next;
        m_reg      <= m_next;
        msq_reg    <= msq_next;
        frac_reg   <= frac_next;
        lg_i_reg   <= lg_i_next;
        dbp_reg    <= dbp_next;
        db_reg     <= db_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_PIXELS))
        else $error("kept count beyond store depth");
    a_write_only_loading: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_LOAD) && !s1_v_reg)
        else $error("store written during the deviation pass");
    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_v_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the hand-over state");
    a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divide started while busy");
endmodule

@@ rtl/wss_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module wss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/wss_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module wss_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wss_pkg::wss_div_req_t req,
    output wss_pkg::wss_div_rsp_t rsp
);
    import wss_pkg::*;

    localparam int STEP_W = $clog2(DVD_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   rem_reg, rem_next;
    logic [DVS_W:0]   rem_sh;

    // Shift one dividend bit into the remainder and subtract when it fits
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        rem_sh    = {rem_reg[DVS_W-1:0], dvd_reg[DVD_W-1]};
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

    // A start is only taken while idle, and a finished run always raises done
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !done_reg)
        else $error("divider done while busy");
    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a run");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done longer than one cycle");
endmodule

@@ dv/wss_tb_if.sv @@
`timescale 1ns / 100ps
// Testbench-side helpers: none beyond the RTL interfaces; this file holds the result record type.
package wss_tb_pkg;

    typedef struct packed {
        logic [12:0]        valid_count;
        logic signed [31:0] mean_value;
        logic [30:0]        std_deviation;
        logic signed [31:0] min_value;
        logic signed [31:0] max_value;
        logic signed [31:0] snr_linear;
        logic signed [15:0] snr_decibel;
    } window_stats_t;

endpackage

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the window SNR statistics block.
module testbench;
    import wss_pkg::*;
    import wss_tb_pkg::*;

    localparam int NPIX = 4096;
    localparam longint LIMIT = 4000000;
    localparam int HOLD_CYCLES = 3000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    wss_pix_if pix ();
    wss_res_if res ();
    wss_cfg_if cfg ();

    window_snr_statistics_top dut (.clk(clk), .rst_n(rst_n), .pix(pix), .res(res), .cfg(cfg));

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state
    logic               mask_on;
    logic signed [31:0] mask_value;
    logic [30:0]        mask_tol;
    logic signed [31:0] win_store [NPIX];
    int unsigned        win_count;
    longint             win_sum;
    logic signed [31:0] win_min, win_max;

    window_stats_t stats_due [$];
    int  errors = 0;
    int  pred_errors = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_go = 0;
    bit  hold_off = 0;
    longint cycle = 0;

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint log2_fix(logic [31:0] x);
        int msb;
        longint unsigned m;
        longint f;
        msb = 31;
        f = 0;
        while (x[msb] == 1'b0) msb--;
        m = (64'(x) << (62 - msb)) >> 32;
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            f <<= 1;
            if (m >= (64'd2 << 30))
            begin
                f |= 1;
                m >>= 1;
            end
        end
        return longint'(msb - 16) * 65536 + f;
    endfunction

    // Fold one pixel word into the window; queue expected stats on the last word
    task automatic predict_window(logic signed [31:0] px, logic nf, logic last);
        longint d, mean, snr, db, t;
        longint unsigned ad, q, sq, dsum, sd, am, r;
        logic drop;
        window_stats_t s;
        drop = nf;
        if (!drop && mask_on)
        begin
            d = longint'(px) - longint'(mask_value);
            ad = d < 0 ? -d : d;
            if (ad < 64'(mask_tol)) drop = 1'b1;
        end
        if (!drop && win_count < NPIX)
        begin
            win_store[win_count] = px;
            if (win_count == 0 || px < win_min) win_min = px;
            if (win_count == 0 || px > win_max) win_max = px;
            win_sum += px;
            win_count++;
        end
        if (!last) return;
        mean = 0; sd = 0; snr = 0; db = 0;
        if (win_count > 0)
        begin
            ad = win_sum < 0 ? -win_sum : win_sum;
            q = (ad + win_count / 2) / win_count;
            mean = win_sum < 0 ? -longint'(q) : longint'(q);
            dsum = 0;
            for (int i = 0; i < win_count; i++)
            begin
                d = longint'(win_store[i]) - mean;
                ad = d < 0 ? -d : d;
                sq = ad * ad;
                if (dsum > 64'hFFFF_FFFF_FFFF_FFFF - sq) dsum = 64'hFFFF_FFFF_FFFF_FFFF;
                else dsum += sq;
            end
            if (win_count > 1)
            begin
                sd = root64(dsum / (win_count - 1));
                if (sd > 64'h7FFF_FFFF) sd = 64'h7FFF_FFFF;
            end
            if (sd > 0)
            begin
                am = 64'(mean < 0 ? -mean : mean) << 16;
                r = am / sd;
                if (mean < 0) snr = r > 64'h8000_0000 ? -64'sh8000_0000 : -longint'(r);
                else snr = r > 64'h7FFF_FFFF ? 64'sh7FFF_FFFF : longint'(r);
            end
            if (snr > 0)
            begin
                t = log2_fix(snr[31:0]) * 394566 + (64'sd1 << 23);
                db = t >>> 24;
                if (db > 32767) db = 32767;
                if (db < -32768) db = -32768;
            end
        end
        s.valid_count   = 13'(win_count);
        s.mean_value    = mean[31:0];
        s.std_deviation = sd[30:0];
        s.min_value     = win_count > 0 ? win_min : 32'sd0;
        s.max_value     = win_count > 0 ? win_max : 32'sd0;
        s.snr_linear    = snr[31:0];
        s.snr_decibel   = db[15:0];
        stats_due = {stats_due, s};
        win_count = 0;
        win_sum = 0;
        win_min = 0;
        win_max = 0;
    endtask

    // Drive one pixel word and wait for acceptance; valid stays high for the next word
    task automatic send_pixel(logic signed [31:0] px, logic nf, logic last);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            pix.valid <= 1'b0;
            @(negedge clk);
        end
        pix.valid <= 1'b1;
        pix.pixel_value <= px;
        pix.not_finite <= nf;
        pix.last_of_window <= last;
        do @(posedge clk); while (!pix.ready);
        predict_window(px, nf, last);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg.valid <= 1'b1;
        cfg.reg_index <= idx;
        cfg.wdata <= val;
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            CFG_NODATA_ENABLE:    mask_on = val[0];
            CFG_NODATA_VALUE:     mask_value = val;
            CFG_NODATA_TOLERANCE: mask_tol = val[30:0];
            default: ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Stop sending, wait for every outstanding result, then let the block settle
    task automatic drain();
        pix.valid <= 1'b0;
        while (stats_due.size() != 0) @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    task automatic rand_window(int n, bit mask_hits);
        logic signed [31:0] px;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(5))
                0: px = $urandom;
                1: px = $signed(32'($urandom_range(65536 * 4))) - 32'sd65536;
                2: px = mask_hits ? mask_value + $signed(32'($urandom_range(6))) - 3
                                  : 32'($urandom_range(100));
                default: px = 32'sd1000000 + $signed(32'($urandom_range(65536)));
            endcase
            send_pixel(px, $urandom_range(15) == 0, i == n - 1);
        end
    endtask

    // Long receiver hold-off, counted here once requested
    initial
    begin
        wait (hold_go);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
    end

    // Receiver: random stall, plus the long hold-off
    always @(negedge clk)
        res.ready <= !hold_off && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);

    // Compare accepted results with the oldest expectation
    always @(posedge clk)
    begin
        window_stats_t e;
        cycle <= cycle + 1;
        if (rst_n && res.valid && res.ready)
        begin
            if (stats_due.size() == 0)
            begin
                $error("result with no expectation waiting");
                errors++;
            end
            else
            begin
                e = stats_due.pop_front();
                if (res.valid_count !== e.valid_count)
                begin
                    $error("valid_count exp %0d got %0d", e.valid_count, res.valid_count);
                    errors++;
                end
                if (res.mean_value !== e.mean_value)
                begin
                    $error("mean_value exp %0d got %0d", e.mean_value, res.mean_value);
                    errors++;
                end
                if (res.std_deviation !== e.std_deviation)
                begin
                    $error("std_deviation exp %0d got %0d", e.std_deviation, res.std_deviation);
                    errors++;
                end
                if (res.min_value !== e.min_value)
                begin
                    $error("min_value exp %0d got %0d", e.min_value, res.min_value);
                    errors++;
                end
                if (res.max_value !== e.max_value)
                begin
                    $error("max_value exp %0d got %0d", e.max_value, res.max_value);
                    errors++;
                end
                if (res.snr_linear !== e.snr_linear)
                begin
                    $error("snr_linear exp %0d got %0d", e.snr_linear, res.snr_linear);
                    errors++;
                end
                if (res.snr_decibel !== e.snr_decibel)
                begin
                    $error("snr_decibel exp %0d got %0d", e.snr_decibel, res.snr_decibel);
                    errors++;
                end
            end
        end
        if (cycle > LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Directed table: pixel, not-finite flag, last flag
    typedef struct {
        logic signed [31:0] px;
        logic nf;
        logic last;
    } pix_row_t;

    pix_row_t rows [] = '{
        '{32'sd0, 1'b1, 1'b1},                  // empty window
        '{32'sh7FFF_FFFF, 1'b0, 1'b1},          // single pixel, top extreme
        '{-32'sh8000_0000, 1'b0, 1'b1},         // single pixel, bottom extreme
        '{32'sh7FFF_FFFF, 1'b0, 1'b0},          // two extremes: std deviation saturates
        '{-32'sh8000_0000, 1'b0, 1'b1},
        '{32'sd65536, 1'b0, 1'b0},              // positive SNR
        '{32'sd131072, 1'b0, 1'b0},
        '{32'sd5, 1'b1, 1'b1},                  // last word dropped
        '{-32'sd65536, 1'b0, 1'b0},             // negative mean
        '{-32'sd196608, 1'b0, 1'b1},
        '{32'sd1000, 1'b0, 1'b0},               // equal pixels: std zero
        '{32'sd1000, 1'b0, 1'b1},
        '{-32'sd1, 1'b0, 1'b0},                 // small values, rounding of mean
        '{32'sd0, 1'b0, 1'b0},
        '{32'sd0, 1'b0, 1'b1},
        '{32'sd0, 1'b0, 1'b0},                  // masked (value 0, tol 1 once on)
        '{32'sd1, 1'b0, 1'b1}
    };

    initial
    begin
        logic [31:0] v;
        int n;
        pix.valid = 1'b0;
        pix.pixel_value = '0;
        pix.not_finite = 1'b0;
        pix.last_of_window = 1'b0;
        cfg.valid = 1'b0;
        cfg.reg_index = CFG_NODATA_ENABLE;
        cfg.wdata = '0;
        mask_on = 1'b0;
        mask_value = '0;
        mask_tol = 31'd1;
        win_count = 0;
        win_sum = 0;
        win_min = 0;
        win_max = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part; the empty window is known without prediction
        foreach (rows[i])
        begin
            if (i == 15)
            begin
                drain();
                write_reg(CFG_NODATA_ENABLE, 32'd1);
            end
            send_pixel(rows[i].px, rows[i].nf, rows[i].last);
            if (i == 0 && stats_due[0] !== window_stats_t'('0))
            begin
                $error("empty window prediction not zero");
                pred_errors++;
            end
        end

        // Long receiver hold-off: later windows back up into the input
        drain();
        hold_go = 1'b1;
        rand_window(300, 0);
        rand_window(20, 0);
        rand_window(10, 0);

        // Random phases through idling settings and register settings
        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            case (ph)
                0: v = 32'h8000_0000;
                1: v = 32'h7FFF_FFFF;
                default: v = $urandom;
            endcase
            write_reg(CFG_NODATA_ENABLE, 32'(ph % 2));
            write_reg(CFG_NODATA_VALUE, v);
            write_reg(CFG_NODATA_TOLERANCE, ph == 2 ? 32'h7FFF_FFFF : 32'($urandom_range(4)));
            n = 0;
            while (n < 180)
            begin
                int w;
                w = $urandom_range(8) == 0 ? $urandom_range(60, 120) : $urandom_range(1, 12);
                rand_window(w, 1);
                n += w;
            end
        end

        drain();
        if (errors == 0 && pred_errors == 0 && stats_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

@@ window_snr_statistics_top.f @@
rtl/wss_pkg.sv
rtl/wss_if.sv
rtl/wss_ram.sv
rtl/wss_div.sv
rtl/window_snr_statistics_top.sv
dv/wss_tb_if.sv
dv/testbench.sv
